// ===== sv/first_fit_extent_allocator_core_macros.svh =====
// Assertion macros for the first-fit extent allocator checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef FIRST_FIT_EXTENT_ALLOCATOR_CORE_MACROS_SVH
`define FIRST_FIT_EXTENT_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset
`define FFEA_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
else $error(msg);

// Next-cycle implication, checked out of reset
`define FFEA_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
else $error(msg);

`endif

// ===== sv/ffea_pkg.sv =====
// Shared types and constants of the first-fit extent allocator.
// No dependencies; used by every module of the block.
package ffea_pkg;

    localparam int MAX_EXTENTS_DEF = 16;
    localparam int ADDR_WIDTH_DEF  = 16;
    localparam int FIELD_W         = 16;
    localparam int MODE_W          = 2;
    localparam int CNT_OUT_W       = 5;

    localparam logic [FIELD_W-1:0] POOL_RESET = 16'hFFFF;

    localparam logic [MODE_W-1:0] MODE_ALLOC  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FREE   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REINIT = 2'd2;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_FIT     = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_BAD_SIZE   = 2'd3
    } t_status;

    // Kind of pass the head unit runs over the chain
    typedef enum logic [1:0] {
        PK_ALLOC = 2'd0,
        PK_FREE  = 2'd1,
        PK_DROP  = 2'd2
    } t_pass;

    typedef struct packed {
        logic shift;
        logic push;
        logic init;
    } t_cell_ctrl;

    typedef struct packed {
        t_pass kind;
        logic  start;
        logic  step;
        logic  flush;
        logic  first;
    } t_head_ctrl;

endpackage

// ===== sv/ffea_cell.sv =====
// One cell of the extent chain: holds one free extent and shifts toward the head.
// Depends on ffea_pkg.
module ffea_cell #(
    parameter int INDEX = 0,
    parameter int AW    = ffea_pkg::ADDR_WIDTH_DEF,
    parameter int IW    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ffea_pkg::t_cell_ctrl i_ctrl,
    input  logic [IW-1:0]        i_wr_idx,
    input  logic [AW-1:0]        i_init_len,
    input  logic                 i_nb_vld,
    input  logic                 i_nb_tag,
    input  logic [AW-1:0]        i_nb_start,
    input  logic [AW-1:0]        i_nb_len,
    input  logic                 i_push_tag,
    input  logic [AW-1:0]        i_push_start,
    input  logic [AW-1:0]        i_push_len,
    output logic                 o_vld,
    output logic                 o_tag,
    output logic [AW-1:0]        o_start,
    output logic [AW-1:0]        o_len
);
    import ffea_pkg::*;

    logic          r_vld;
    logic          r_tag;
    logic [AW-1:0] r_start;
    logic [AW-1:0] r_len;
    logic          w_hit;

    assign w_hit = i_ctrl.push && (i_wr_idx == IW'(INDEX));

    // Load the whole pool, take a pushed extent, or shift from the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.init) begin
            r_vld   <= (INDEX == 0) && (i_init_len != '0);
            r_tag   <= 1'b0;
            r_start <= '0;
            r_len   <= i_init_len;
        end else if (w_hit) begin
            r_vld   <= 1'b1;
            r_tag   <= i_push_tag;
            r_start <= i_push_start;
            r_len   <= i_push_len;
        end else if (i_ctrl.shift) begin
            r_vld   <= i_nb_vld;
            r_tag   <= i_nb_tag;
            r_start <= i_nb_start;
            r_len   <= i_nb_len;
        end
    end

    assign o_vld   = r_vld;
    assign o_tag   = r_tag;
    assign o_start = r_start;
    assign o_len   = r_len;

endmodule

// ===== sv/ffea_head.sv =====
// Head unit: edits the extent stream leaving the chain and merges touching extents.
// Depends on ffea_pkg.
module ffea_head #(
    parameter int AW = ffea_pkg::ADDR_WIDTH_DEF,
    parameter int DW = ffea_pkg::FIELD_W
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffea_pkg::t_head_ctrl        i_ctrl,
    input  logic [ffea_pkg::FIELD_W-1:0] i_req_size,
    input  logic [ffea_pkg::FIELD_W-1:0] i_req_addr,
    input  logic                        i_h_vld,
    input  logic                        i_h_tag,
    input  logic [AW-1:0]               i_h_start,
    input  logic [AW-1:0]               i_h_len,
    output logic                        o_push,
    output logic                        o_push_tag,
    output logic [AW-1:0]               o_push_start,
    output logic [AW-1:0]               o_push_len,
    output logic                        o_found,
    output logic [AW-1:0]               o_grant
);
    import ffea_pkg::*;

    logic          r_acc_vld;
    logic          r_acc_tag;
    logic [AW-1:0] r_acc_start;
    logic [AW-1:0] r_acc_len;
    logic          r_ins;
    logic [AW-1:0] r_hold_start;
    logic [AW-1:0] r_hold_len;
    logic          r_hold_vld;
    logic          r_found;
    logic [AW-1:0] r_grant;

    logic          w_s_vld;
    logic          w_s_tag;
    logic [AW-1:0] w_s_start;
    logic [AW-1:0] w_s_len;
    logic          w_ins_cond;
    logic          w_take_hold;
    logic          w_hit;
    logic          w_touch;

    // Insert point: strictly below the first start, else at or below later ones
    assign w_ins_cond = !i_h_vld ||
        (i_ctrl.first ? (DW'(i_h_start) > DW'(i_req_addr))
                      : (DW'(i_h_start) >= DW'(i_req_addr)));

    assign w_hit = !r_found && i_h_vld && (DW'(i_h_len) >= DW'(i_req_size));

    // Build the stream item for this cycle
    always_comb begin
        w_s_vld     = i_h_vld;
        w_s_tag     = 1'b0;
        w_s_start   = i_h_start;
        w_s_len     = i_h_len;
        w_take_hold = 1'b0;
        case (i_ctrl.kind)
            PK_FREE: begin
                if (r_ins) begin
                    w_s_vld     = r_hold_vld;
                    w_s_start   = r_hold_start;
                    w_s_len     = r_hold_len;
                    w_take_hold = 1'b1;
                end else if (w_ins_cond) begin
                    w_s_vld     = 1'b1;
                    w_s_tag     = 1'b1;
                    w_s_start   = AW'(i_req_addr);
                    w_s_len     = AW'(i_req_size);
                    w_take_hold = 1'b1;
                end
            end
            PK_ALLOC: begin
                if (w_hit) begin
                    if (DW'(i_h_len) == DW'(i_req_size)) begin
                        w_s_vld = 1'b0;
                    end else begin
                        w_s_start = AW'(DW'(i_h_start) + DW'(i_req_size));
                        w_s_len   = AW'(DW'(i_h_len) - DW'(i_req_size));
                    end
                end
            end
            PK_DROP: begin
                w_s_vld = i_h_vld && !i_h_tag;
            end
            default: begin
                w_s_vld = i_h_vld;
            end
        endcase
    end

    assign w_touch = (i_ctrl.kind == PK_FREE) && r_acc_vld && w_s_vld &&
        ((AW+1)'(r_acc_start) + (AW+1)'(r_acc_len) == (AW+1)'(w_s_start));

    // Emit the held extent once the next one does not touch it, or when the pass is flushed
    assign o_push = i_ctrl.step ? (r_acc_vld && !w_touch) : (i_ctrl.flush && r_acc_vld);
    assign o_push_tag   = r_acc_tag;
    assign o_push_start = r_acc_start;
    assign o_push_len   = r_acc_len;
    assign o_found      = r_found;
    assign o_grant      = r_grant;

    // Control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.start || i_ctrl.flush) begin
            r_acc_vld <= 1'b0;
        end else if (i_ctrl.step && !w_touch) begin
            r_acc_vld <= w_s_vld;
        end
        if (!i_rst_n || i_ctrl.start) begin
            r_ins   <= 1'b0;
            r_found <= 1'b0;
        end else if (i_ctrl.step) begin
            if (w_take_hold) r_ins <= 1'b1;
            if (i_ctrl.kind == PK_ALLOC && w_hit) r_found <= 1'b1;
        end
    end

    // Accumulate, delay and grant payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.step) begin
            if (w_touch) begin
                r_acc_len <= AW'(r_acc_len + w_s_len);
                r_acc_tag <= r_acc_tag | w_s_tag;
            end else begin
                r_acc_tag   <= w_s_tag;
                r_acc_start <= w_s_start;
                r_acc_len   <= w_s_len;
            end
            if (w_take_hold) begin
                r_hold_vld   <= i_h_vld;
                r_hold_start <= i_h_start;
                r_hold_len   <= i_h_len;
            end
            if (i_ctrl.kind == PK_ALLOC && w_hit) r_grant <= i_h_start;
        end
    end

endmodule

// ===== sv/first_fit_extent_allocator_core.sv =====
// First-fit extent allocator: a chain of MAX_EXTENTS+1 cells rotates through a head unit.
// Allocate and free each run one pass of the chain through the head unit, then a flush;
// a free that overflows the table adds a restoring pass that drops the new extent again.
// Reinit and unused modes go straight to the result. One item is worked on at a time.
// Synchronous active-low reset loads one extent covering the pool (size 65535 clipped).
// Depends on ffea_pkg, ffea_cell and ffea_head.
module first_fit_extent_allocator_core #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF,
    parameter int ADDR_WIDTH  = ffea_pkg::ADDR_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [ffea_pkg::MODE_W-1:0]    i_mode,
    input  logic [ffea_pkg::FIELD_W-1:0]   i_block_size,
    input  logic [ffea_pkg::FIELD_W-1:0]   i_block_address,
    input  logic                           i_wr_en,
    input  logic [ffea_pkg::FIELD_W-1:0]   i_wr_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [ffea_pkg::FIELD_W-1:0]   o_result_address,
    output logic [1:0]                     o_status,
    output logic [ffea_pkg::CNT_OUT_W-1:0] o_free_extent_count
);
    import ffea_pkg::*;

    localparam int M  = MAX_EXTENTS + 1;
    localparam int AW = ADDR_WIDTH;
    localparam int DW = (AW > FIELD_W) ? AW : FIELD_W;
    localparam int IW = $clog2(M);
    localparam int CW = $clog2(M + 1);

    typedef enum logic [1:0] {S_IDLE, S_PASS, S_FLUSH, S_DONE} t_state;

    t_state               r_state;
    t_pass                r_kind;
    t_status              r_status;
    logic [FIELD_W-1:0]   r_size;
    logic [FIELD_W-1:0]   r_addr;
    logic [FIELD_W-1:0]   r_pool;
    logic [FIELD_W-1:0]   r_res_addr;
    logic [IW-1:0]        r_t;
    logic [IW-1:0]        r_wp;
    logic [CW-1:0]        r_cnt;
    logic                 r_out_vld;
    logic [FIELD_W-1:0]   r_out_addr;
    t_status              r_out_status;
    logic [CNT_OUT_W-1:0] r_out_cnt;

    logic [AW-1:0] w_lim;
    logic [AW-1:0] w_lim_rst;
    logic [AW-1:0] w_init_len;
    logic          w_free_bad;
    logic          w_push;
    logic [CW-1:0] w_cnt_nx;
    logic          w_found;
    logic [AW-1:0] w_grant;
    logic          w_push_tag;
    logic [AW-1:0] w_push_start;
    logic [AW-1:0] w_push_len;
    logic [IW-1:0] w_wr_idx;
    t_cell_ctrl    w_cctrl;
    t_head_ctrl    w_hctrl;

    logic          w_vld   [M];
    logic          w_tag   [M];
    logic [AW-1:0] w_start [M];
    logic [AW-1:0] w_len   [M];

    // Pool limit: pool size clipped to the address range
    assign w_lim = (DW'(r_pool) > DW'({AW{1'b1}})) ? {AW{1'b1}} : AW'(r_pool);
    assign w_lim_rst = (DW'(POOL_RESET) > DW'({AW{1'b1}})) ? {AW{1'b1}} : AW'(POOL_RESET);
    assign w_init_len = i_rst_n ? w_lim : w_lim_rst;

    assign w_free_bad = (i_block_size == '0) ||
        ((DW+1)'(i_block_address) + (DW+1)'(i_block_size) > (DW+1)'(w_lim));

    assign o_stall = (r_state != S_IDLE);

    // Cell and head controls
    always_comb begin
        w_cctrl.shift = (r_state == S_PASS);
        w_cctrl.push  = w_push && ((r_state == S_PASS) || (r_state == S_FLUSH));
        w_cctrl.init  = i_valid && (r_state == S_IDLE) && (i_mode == MODE_REINIT);
        w_hctrl.kind  = r_kind;
        w_hctrl.start = (r_state == S_IDLE) || (r_state == S_FLUSH);
        w_hctrl.step  = (r_state == S_PASS);
        w_hctrl.flush = (r_state == S_FLUSH);
        w_hctrl.first = (r_t == '0);
    end

    assign w_wr_idx = (r_state == S_PASS) ? r_wp : IW'(r_wp + 1'b1);
    assign w_cnt_nx = r_cnt + CW'(w_push);

    // Row of extent cells
    for (genvar g = 0; g < M; g++) begin : g_cell
        logic          nb_vld;
        logic          nb_tag;
        logic [AW-1:0] nb_start;
        logic [AW-1:0] nb_len;
        if (g < M - 1) begin : g_nb
            assign nb_vld   = w_vld[g+1];
            assign nb_tag   = w_tag[g+1];
            assign nb_start = w_start[g+1];
            assign nb_len   = w_len[g+1];
        end else begin : g_end
            assign nb_vld   = 1'b0;
            assign nb_tag   = 1'b0;
            assign nb_start = '0;
            assign nb_len   = '0;
        end
        ffea_cell #(.INDEX(g), .AW(AW), .IW(IW)) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctrl       (w_cctrl),
            .i_wr_idx     (w_wr_idx),
            .i_init_len   (w_init_len),
            .i_nb_vld     (nb_vld),
            .i_nb_tag     (nb_tag),
            .i_nb_start   (nb_start),
            .i_nb_len     (nb_len),
            .i_push_tag   (w_push_tag),
            .i_push_start (w_push_start),
            .i_push_len   (w_push_len),
            .o_vld        (w_vld[g]),
            .o_tag        (w_tag[g]),
            .o_start      (w_start[g]),
            .o_len        (w_len[g])
        );
    end

    ffea_head #(.AW(AW), .DW(DW)) u_head (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctrl       (w_hctrl),
        .i_req_size   (r_size),
        .i_req_addr   (r_addr),
        .i_h_vld      (w_vld[0]),
        .i_h_tag      (w_tag[0]),
        .i_h_start    (w_start[0]),
        .i_h_len      (w_len[0]),
        .o_push       (w_push),
        .o_push_tag   (w_push_tag),
        .o_push_start (w_push_start),
        .o_push_len   (w_push_len),
        .o_found      (w_found),
        .o_grant      (w_grant)
    );

    // Sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_kind    <= PK_ALLOC;
            r_status  <= ST_OK;
            r_pool    <= POOL_RESET;
            r_cnt     <= CW'(1);
            r_t       <= '0;
            r_wp      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_wr_en) r_pool <= i_wr_data;
            if (r_out_vld && !i_stall && (r_state != S_DONE)) r_out_vld <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_size     <= i_block_size;
                        r_addr     <= i_block_address;
                        r_res_addr <= '0;
                        r_t        <= '0;
                        r_wp       <= IW'(M - 1);
                        case (i_mode)
                            MODE_ALLOC: begin
                                if (i_block_size == '0) begin
                                    r_status <= ST_BAD_SIZE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_kind   <= PK_ALLOC;
                                    r_cnt    <= '0;
                                    r_state  <= S_PASS;
                                end
                            end
                            MODE_FREE: begin
                                if (w_free_bad) begin
                                    r_status <= ST_BAD_SIZE;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_status <= ST_OK;
                                    r_kind   <= PK_FREE;
                                    r_cnt    <= '0;
                                    r_state  <= S_PASS;
                                end
                            end
                            MODE_REINIT: begin
                                r_status <= ST_OK;
                                r_cnt    <= (w_lim != '0) ? CW'(1) : '0;
                                r_state  <= S_DONE;
                            end
                            default: begin
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        endcase
                    end
                end
                S_PASS: begin
                    r_t <= IW'(r_t + 1'b1);
                    if (w_push) begin
                        r_cnt <= w_cnt_nx;
                    end else begin
                        r_wp <= IW'(r_wp - 1'b1);
                    end
                    if (r_t == IW'(M - 1)) r_state <= S_FLUSH;
                end
                S_FLUSH: begin
                    case (r_kind)
                        PK_ALLOC: begin
                            r_cnt      <= w_cnt_nx;
                            r_state    <= S_DONE;
                            r_status   <= w_found ? ST_OK : ST_NO_FIT;
                            r_res_addr <= w_found ? FIELD_W'(w_grant) : '0;
                        end
                        PK_FREE: begin
                            // Overflow: run a pass that drops the new extent again
                            if (w_cnt_nx == CW'(M)) begin
                                r_kind  <= PK_DROP;
                                r_t     <= '0;
                                r_wp    <= IW'(M - 1);
                                r_cnt   <= '0;
                                r_state <= S_PASS;
                            end else begin
                                r_cnt    <= w_cnt_nx;
                                r_status <= ST_OK;
                                r_state  <= S_DONE;
                            end
                        end
                        PK_DROP: begin
                            r_cnt    <= w_cnt_nx;
                            r_status <= ST_TABLE_FULL;
                            r_state  <= S_DONE;
                        end
                        default: begin
                            r_cnt    <= w_cnt_nx;
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_DONE: begin
                    if (!r_out_vld || !i_stall) begin
                        r_out_vld    <= 1'b1;
                        r_out_addr   <= r_res_addr;
                        r_out_status <= r_status;
                        r_out_cnt    <= CNT_OUT_W'(r_cnt);
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid             = r_out_vld;
    assign o_result_address    = r_out_addr;
    assign o_status            = r_out_status;
    assign o_free_extent_count = r_out_cnt;

endmodule

// ===== sv/ffea_checker.sv =====
// Port-level checks on the result channel of the first-fit extent allocator.
// Depends on ffea_pkg and first_fit_extent_allocator_core_macros.svh; bound to the top.
`include "first_fit_extent_allocator_core_macros.svh"

module ffea_checker #(
    parameter int MAX_EXTENTS = ffea_pkg::MAX_EXTENTS_DEF
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_valid,
    input logic                           i_stall,
    input logic [ffea_pkg::FIELD_W-1:0]   o_result_address,
    input logic [1:0]                     o_status,
    input logic [ffea_pkg::CNT_OUT_W-1:0] o_free_extent_count
);
    import ffea_pkg::*;

    // Only a granted allocation carries an address
    `FFEA_ASSERT_NOW(a_addr_zero, o_valid && (o_status != ST_OK), o_result_address == '0, "address on failed item")

    // Table never reports more extents than it holds
    `FFEA_ASSERT_NOW(a_cnt_max, o_valid, (MAX_EXTENTS > 31) || (32'(o_free_extent_count) <= 32'(MAX_EXTENTS)), "extent count too large")

    // A dropped free leaves a full table
    `FFEA_ASSERT_NOW(a_full_cnt, o_valid && (o_status == ST_TABLE_FULL), o_free_extent_count == CNT_OUT_W'(MAX_EXTENTS), "table full with room left")

    // Hold a stalled result item
    `FFEA_ASSERT_NEXT(a_hold, o_valid && i_stall, o_valid && $stable(o_status) && $stable(o_result_address), "stalled item changed")

endmodule

bind first_fit_extent_allocator_core ffea_checker #(.MAX_EXTENTS(MAX_EXTENTS)) u_ffea_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_result_address    (o_result_address),
    .o_status            (o_status),
    .o_free_extent_count (o_free_extent_count)
);
